### sv/tli_pkg.sv
package tli_pkg;

  localparam int DATA_W         = 32;
  localparam int STAT_W         = 2;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MIN_POINTS     = 2;
  localparam int MAG_W          = 32;
  localparam int PROD_W         = 2 * MAG_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_MUL,
    ALU_DIV,
    ALU_RND
  } tli_alu_op_e;

  typedef struct packed {
    logic        load;
    tli_alu_op_e op;
  } tli_alu_ctl_t;

endpackage

### sv/tli_if.sv
interface tli_in_if;
  import tli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         point_index;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, opcode, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink (input valid, opcode, point_index, point_x, point_y, query_x,
                output ready);
endinterface

interface tli_out_if;
  import tli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

### sv/tli_ram.sv
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tli_alu.sv
module tli_alu (
  input  logic                         clk_i,
  input  tli_pkg::tli_alu_ctl_t        ctl_i,
  input  logic [tli_pkg::MAG_W-1:0]    mdx_i,
  input  logic [tli_pkg::MAG_W-1:0]    mdy_i,
  input  logic [tli_pkg::MAG_W-1:0]    mdq_i,
  output logic [tli_pkg::PROD_W-1:0]   quo_o
);
  import tli_pkg::*;

  localparam int SW = PROD_W + 1;

  logic [PROD_W-1:0] wrk_q, wrk_d;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  mq_q, mq_d;
  logic [SW-1:0]     add_a, add_b, sum;
  logic              cin;
  logic              rnd;

  // round half away from zero on magnitudes: 2*rem >= divisor
  assign rnd = {rem_q, 1'b0} >= {1'b0, mdx_i};

  // the one shared adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    cin   = 1'b0;
    case (ctl_i.op)
      ALU_MUL: begin
        add_a = {wrk_q, 1'b0};
        add_b = mq_q[MAG_W-1] ? SW'(mdy_i) : '0;
      end
      ALU_DIV: begin
        add_a = SW'({rem_q, wrk_q[PROD_W-1]});
        add_b = ~SW'(mdx_i);
        cin   = 1'b1;
      end
      ALU_RND: begin
        add_a = SW'(wrk_q);
        cin   = rnd;
      end
      default: begin
      end
    endcase
    sum = add_a + add_b + SW'(cin);
  end

  always_comb begin
    wrk_d = wrk_q;
    rem_d = rem_q;
    mq_d  = mq_q;
    if (ctl_i.load) begin
      wrk_d = '0;
      rem_d = '0;
      mq_d  = mdq_i;
    end else begin
      case (ctl_i.op)
        ALU_MUL: begin
          // msb-first shift and add
          wrk_d = sum[PROD_W-1:0];
          mq_d  = {mq_q[MAG_W-2:0], 1'b0};
        end
        ALU_DIV: begin
          // restoring step, quotient bits shift in from the right
          if (!sum[SW-1]) begin
            rem_d = sum[MAG_W-1:0];
          end else begin
            rem_d = {rem_q[MAG_W-2:0], wrk_q[PROD_W-1]};
          end
          wrk_d = {wrk_q[PROD_W-2:0], ~sum[SW-1]};
        end
        ALU_RND: begin
          wrk_d = sum[PROD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wrk_q <= wrk_d;
    rem_q <= rem_d;
    mq_q  <= mq_d;
  end

  assign quo_o = wrk_q;

endmodule

### sv/table_linear_interpolator.sv
// channel  | dir | beat contents
// ---------+-----+--------------------------------------------------------
// in_ch    | in  | opcode, point_index, point_x, point_y, query_x
// out_ch   | out | value, status (one beat per query, none per load)
// cfg      | in  | cfg_we_i / cfg_wdata_i write point_count
//
// a load beat writes the knot rams in the cycle it is taken and leaves the sequencer idle
// a query walks the x ram one knot per cycle, then runs 32 multiply steps,
// 64 divide steps and one rounding step on the shared adder of tli_alu
// in_ch is ready only while the sequencer is idle; a finished result sits in
// the output register, so the next beat is taken while it waits to be drained
// reset clears the sequencer, output valid and point_count (to 2); the knot
// rams are not cleared and hold garbage until loaded
module table_linear_interpolator #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tli_in_if.sink                     in_ch,
  tli_out_if.source                  out_ch,
  input  logic                       cfg_we_i,
  input  logic [tli_pkg::CNT_W-1:0]  cfg_wdata_i
);
  import tli_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int STEPW = $clog2(PROD_W);
  localparam int RW    = DATA_W + 4;   // room for yb +/- clamped quotient

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAST  = 4'd1;   // compare against last knot
  localparam logic [3:0] S_FIRST = 4'd2;   // compare against first knot
  localparam logic [3:0] S_SCAN  = 4'd3;   // linear search
  localparam logic [3:0] S_SEG   = 4'd4;   // issue read of left knot
  localparam logic [3:0] S_SEGA  = 4'd5;   // capture left knot
  localparam logic [3:0] S_SEGB  = 4'd6;   // right knot, form differences
  localparam logic [3:0] S_LOAD  = 4'd7;   // prime the shared unit
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_RND   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;  // clamp and saturate
  localparam logic [3:0] S_PUT   = 4'd12;  // hand result to output register

  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         pc_q;
  logic [AW-1:0]            idx_q, idx_d;
  logic [STEPW-1:0]         step_q, step_d;
  logic signed [DATA_W-1:0] q_q;
  logic [DATA_W-1:0]        xa_q, ya_q, yb_q;
  logic [MAG_W-1:0]         mdx_q, mdy_q, mdq_q;
  logic                     neg_q;
  logic [DATA_W-1:0]        pend_val_q, pend_val_d;
  logic [STAT_W-1:0]        pend_st_q, pend_st_d;
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_val_q;
  logic [STAT_W-1:0]        out_st_q;

  logic                     in_acc, out_acc, put_go;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        x_rdata, y_rdata;
  logic [CW-1:0]            pc_e, n_e;
  logic [AW-1:0]            nlast;
  logic                     q_gt_x, q_lt_x;
  logic [MAG_W:0]           dx, dy, dq;
  logic [MAG_W-1:0]         mdx, mdy, mdq;
  tli_alu_ctl_t             alu_ctl;
  logic [PROD_W-1:0]        quo;
  logic                     quo_big;
  logic [RW-1:0]            quo_c, yb_e, res;
  logic                     sat_hi, sat_lo;

  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W:0] v);
    logic [MAG_W:0] t;
    t = v[MAG_W] ? (~v + 1'b1) : v;
    return t[MAG_W-1:0];
  endfunction

  // handshakes
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_q && out_ch.ready;
  assign put_go      = !out_valid_q || out_ch.ready;

  // knots in use, clamped to [2, MAX_POINTS]
  assign pc_e  = CW'(pc_q);
  assign n_e   = (pc_e < CW'(MIN_POINTS)) ? CW'(MIN_POINTS) :
                 (pc_e > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_e;
  assign nlast = AW'(n_e - CW'(1));

  // loads outside the table are dropped
  assign ram_we    = in_acc && (in_ch.opcode == OP_LOAD) &&
                     (CW'(in_ch.point_index) < CW'(MAX_POINTS));
  assign ram_waddr = AW'(in_ch.point_index);

  // read address is issued in the state before the one that consumes the registered data
  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = nlast;
      S_LAST:  ram_raddr = '0;
      S_FIRST: ram_raddr = AW'(1);
      S_SCAN:  ram_raddr = idx_q + AW'(1);
      S_SEG:   ram_raddr = idx_q - AW'(1);
      default: ram_raddr = idx_q;
    endcase
  end

  tli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_ch.point_x),
    .raddr_i (ram_raddr),
    .rdata_o (x_rdata)
  );

  tli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_ch.point_y),
    .raddr_i (ram_raddr),
    .rdata_o (y_rdata)
  );

  assign q_gt_x = q_q > $signed(x_rdata);
  assign q_lt_x = q_q < $signed(x_rdata);

  // segment differences, each magnitude fits 32 bits
  assign dx  = {x_rdata[DATA_W-1], x_rdata} - {xa_q[DATA_W-1], xa_q};
  assign dy  = {y_rdata[DATA_W-1], y_rdata} - {ya_q[DATA_W-1], ya_q};
  assign dq  = {q_q[DATA_W-1], q_q} - {x_rdata[DATA_W-1], x_rdata};
  assign mdx = mag_of(dx);
  assign mdy = mag_of(dy);
  assign mdq = mag_of(dq);

  always_comb begin
    alu_ctl.load = (state_q == S_LOAD);
    case (state_q)
      S_MUL:   alu_ctl.op = ALU_MUL;
      S_DIV:   alu_ctl.op = ALU_DIV;
      S_RND:   alu_ctl.op = ALU_RND;
      default: alu_ctl.op = ALU_HOLD;
    endcase
  end

  tli_alu u_alu (
    .clk_i (clk_i),
    .ctl_i (alu_ctl),
    .mdx_i (mdx_q),
    .mdy_i (mdy_q),
    .mdq_i (mdq_q),
    .quo_o (quo)
  );

  // quotient clamps at 2^34, then yb +/- quotient saturates to 32 bits
  assign quo_big = (|quo[PROD_W-1:35]) || (quo[34] && (|quo[33:0]));
  assign quo_c   = quo_big ? (RW'(1) << 34) : RW'(quo[34:0]);
  assign yb_e    = RW'($signed(yb_q));
  assign res     = neg_q ? (yb_e - quo_c) : (yb_e + quo_c);
  assign sat_hi  = !res[RW-1] && (|res[RW-2:DATA_W-1]);
  assign sat_lo  = res[RW-1] && !(&res[RW-2:DATA_W-1]);

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    step_d     = step_q;
    pend_val_d = pend_val_q;
    pend_st_d  = pend_st_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_QUERY)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (q_gt_x) begin
          idx_d   = nlast;
          state_d = S_SEG;
        end else begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (q_lt_x) begin
          idx_d   = AW'(1);
          state_d = S_SEG;
        end else if (q_gt_x) begin
          idx_d   = AW'(1);
          state_d = S_SCAN;
        end else begin
          // query on the first knot
          pend_val_d = y_rdata;
          pend_st_d  = ST_OK;
          state_d    = S_PUT;
        end
      end
      S_SCAN: begin
        if ((idx_q == nlast) || !q_gt_x) begin
          state_d = S_SEG;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_SEG: begin
        state_d = S_SEGA;
      end
      S_SEGA: begin
        state_d = S_SEGB;
      end
      S_SEGB: begin
        if (x_rdata == xa_q) begin
          pend_val_d = '0;
          pend_st_d  = ST_ZERO;
          state_d    = S_PUT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        step_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        step_d = step_q + STEPW'(1);
        if (step_q == STEPW'(MAG_W - 1)) begin
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        step_d = step_q + STEPW'(1);
        if (step_q == STEPW'(PROD_W - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sat_hi) begin
          pend_val_d = {1'b0, {(DATA_W-1){1'b1}}};
          pend_st_d  = ST_SAT;
        end else if (sat_lo) begin
          pend_val_d = {1'b1, {(DATA_W-1){1'b0}}};
          pend_st_d  = ST_SAT;
        end else begin
          pend_val_d = res[DATA_W-1:0];
          pend_st_d  = ST_OK;
        end
        state_d = S_PUT;
      end
      S_PUT: begin
        if (put_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= CNT_W'(MIN_POINTS);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if ((state_q == S_PUT) && put_go) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    pend_st_q  <= pend_st_d;
    if (in_acc) begin
      q_q <= in_ch.query_x;
    end
    if (state_q == S_SEGA) begin
      xa_q <= x_rdata;
      ya_q <= y_rdata;
    end
    if (state_q == S_SEGB) begin
      yb_q  <= y_rdata;
      mdx_q <= mdx;
      mdy_q <= mdy;
      mdq_q <= mdq;
      neg_q <= dx[MAG_W] ^ dy[MAG_W] ^ dq[MAG_W];
    end
    if ((state_q == S_PUT) && put_go) begin
      out_val_q <= pend_val_q;
      out_st_q  <= pend_st_q;
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.value  = out_val_q;
  assign out_ch.status = out_st_q;

  // a load finishes in its own cycle, a query starts the search
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == (($past(in_ch.opcode) == OP_QUERY) ? S_LAST : S_IDLE)))
    else $error("sequencer did not react to accepted beat");

  // zero-width segment reports a zero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q == ST_ZERO)) |-> (out_val_q == '0))
    else $error("zero-width status with nonzero value");

  // saturation lands exactly on a 32-bit bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q == ST_SAT)) |->
      ((out_val_q == {1'b0, {(DATA_W-1){1'b1}}}) ||
       (out_val_q == {1'b1, {(DATA_W-1){1'b0}}})))
    else $error("saturated result off the bound");

  // the search never points past the last knot in use
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= nlast))
    else $error("search index beyond table");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tli_pkg::*;

  localparam int     RAND_ITEMS  = 1450;
  localparam int     SETTLE      = 200;      // longer than the slowest query
  localparam int     HOLD_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam int     PLAN_LEN    = 8;
  // knot counts for the first phases: out-of-range codes and the edges
  localparam int     COUNT_PLAN [PLAN_LEN] = '{0, 1, 64, 127, 3, 65, 2, 100};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
  } interp_t;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] qx;
    logic                     chk;
    interp_t                  res;
  } dir_row_t;

  localparam interp_t NO_RES = '0;

  // directed beats at the reset knot count of 2; chk marks a result typed in here
  localparam int DIR_LEN = 25;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{OP_LOAD,  6'd0,  32'h0000_0000, 32'h0001_0000, 32'h0, 1'b0, NO_RES},
    '{OP_LOAD,  6'd1,  32'h0002_0000, 32'h0003_0000, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0000_0000, 1'b1, '{32'h0001_0000, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0001_0000, 1'b1, '{32'h0002_0000, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0002_0000, 1'b1, '{32'h0003_0000, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'hFFFF_0000, 1'b1, '{32'h0000_0000, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0004_0000, 1'b1, '{32'h0005_0000, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, ST_SAT}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h8000_0000, 1'b1, '{32'h8001_0000, ST_OK}},
    // tiny slope: rounding ties go away from zero
    '{OP_LOAD,  6'd1,  32'h0003_0000, 32'h0000_0001, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0001_8000, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0001_0000, 1'b0, NO_RES},
    // zero-width segment
    '{OP_LOAD,  6'd1,  32'h0000_0000, 32'h1234_5678, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0000_0005, 1'b1, '{32'h0000_0000, ST_ZERO}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'hFFFF_FFFB, 1'b1, '{32'h0000_0000, ST_ZERO}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0000_0000, 1'b0, NO_RES},
    // steep drop clamps to the negative bound
    '{OP_LOAD,  6'd1,  32'h0000_0001, 32'h8000_0000, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0000_0002, 1'b1, '{32'h8000_0000, ST_SAT}},
    // knots at the field extremes
    '{OP_LOAD,  6'd0,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_RES},
    '{OP_LOAD,  6'd1,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h0000_0000, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK}},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK}},
    '{OP_LOAD,  6'd63, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0, NO_RES},
    '{OP_QUERY, 6'd0,  32'h0, 32'h0, 32'h1234_5678, 1'b0, NO_RES}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  tli_in_if  in_bus ();
  tli_out_if out_bus ();

  table_linear_interpolator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // mirror of the knot table and the count register
  longint           knot_x [MAX_POINTS_DEF];
  longint           knot_y [MAX_POINTS_DEF];
  logic [CNT_W-1:0] knot_count = CNT_W'(MIN_POINTS);
  interp_t          interp_q [$];

  int     fails        = 0;
  int     items_sent   = 0;
  int     results_seen = 0;
  longint cycles       = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int active_knots();
    int n;
    n = knot_count;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    return n;
  endfunction

  // segment search, exact quotient, one rounding step, then clamp
  function automatic interp_t interpolate(logic signed [DATA_W-1:0] qx);
    int        n, i;
    longint    q, xa, xb, ya, yb, dx, dy, dq, res;
    bit [63:0] mdx, mdy, mdq, prod, quo, rem;
    bit        ndx, ndy, ndq;
    interp_t   r;
    n = active_knots();
    q = longint'(qx);
    r.status = ST_OK;
    if (q > knot_x[n-1]) begin
      i = n - 1;
    end else if (q < knot_x[0]) begin
      i = 1;
    end else begin
      i = 0;
      while (i < n - 1 && q > knot_x[i]) i++;
      if (i == 0) begin
        r.value = knot_y[0][31:0];
        return r;
      end
    end
    xa = knot_x[i-1];
    xb = knot_x[i];
    ya = knot_y[i-1];
    yb = knot_y[i];
    dx = xb - xa;
    if (dx == 0) begin
      r.value  = '0;
      r.status = ST_ZERO;
      return r;
    end
    dy  = yb - ya;
    dq  = q - xb;
    ndx = dx < 0;
    ndy = dy < 0;
    ndq = dq < 0;
    mdx = ndx ? -dx : dx;
    mdy = ndy ? -dy : dy;
    mdq = ndq ? -dq : dq;
    prod = mdy * mdq;
    quo  = prod / mdx;
    rem  = prod % mdx;
    if (rem >= mdx - rem) quo = quo + 64'd1;
    if (quo > (64'd1 << 34)) quo = 64'd1 << 34;
    res = (ndx ^ ndy ^ ndq) ? yb - longint'(quo) : yb + longint'(quo);
    if (res > SAT_HI) begin
      res      = SAT_HI;
      r.status = ST_SAT;
    end else if (res < SAT_LO) begin
      res      = SAT_LO;
      r.status = ST_SAT;
    end
    r.value = res[31:0];
    return r;
  endfunction

  // offers one beat, with random idle cycles ahead of it outside the quiet window
  task automatic issue(input logic op, input logic [IDX_W-1:0] idx,
                       input logic signed [DATA_W-1:0] px, py, qx,
                       input logic chk, input interp_t fixed_res);
    while (!(items_sent >= 600 && items_sent < 800) && $urandom_range(99) < 9) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= op;
    in_bus.point_index <= idx;
    in_bus.point_x     <= px;
    in_bus.point_y     <= py;
    in_bus.query_x     <= qx;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    if (op == OP_LOAD) begin
      knot_x[idx] = longint'(px);
      knot_y[idx] = longint'(py);
    end else begin
      interp_q.push_back(chk ? fixed_res : interpolate(qx));
    end
  endtask

  // sender stops until every pending result is out, then lets the block settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (interp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_knot_count(input logic [CNT_W-1:0] cnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    knot_count = cnt;
    cfg_we    <= 1'b0;
  endtask

  // fills every knot in use: small ascending grids, grids with repeated x,
  // full-range sorted tables and unsorted ones
  task automatic load_table();
    int     n, style, i, j;
    longint tx [MAX_POINTS_DEF];
    longint ty [MAX_POINTS_DEF];
    longint t, step;
    n     = active_knots();
    style = $urandom_range(99);
    for (i = 0; i < n; i++) begin
      if (style < 60) begin
        step = longint'($urandom_range(32'h3_0000, 1));
        if (style >= 45 && $urandom_range(3) == 0) step = 0;
        if (i == 0) tx[i] = longint'($urandom_range(32'h20_0000)) - 64'sh10_0000;
        else tx[i] = tx[i-1] + step;
        ty[i] = longint'($urandom_range(32'h80_0000)) - 64'sh40_0000;
      end else begin
        tx[i] = longint'($signed($urandom));
        ty[i] = longint'($signed($urandom));
      end
    end
    if (style >= 60 && style < 85) begin
      for (i = 1; i < n; i++) begin
        t = tx[i];
        j = i - 1;
        while (j >= 0 && tx[j] > t) begin
          tx[j+1] = tx[j];
          j--;
        end
        tx[j+1] = t;
      end
    end
    if ($urandom_range(1) == 0) begin
      for (i = 0; i < n; i++)
        issue(OP_LOAD, IDX_W'(i), tx[i][31:0], ty[i][31:0], $urandom, 1'b0, NO_RES);
    end else begin
      for (i = n - 1; i >= 0; i--)
        issue(OP_LOAD, IDX_W'(i), tx[i][31:0], ty[i][31:0], $urandom, 1'b0, NO_RES);
    end
  endtask

  // queries aimed at knots, inside segments, just outside the table, or anywhere
  task automatic random_query();
    int     n, k, r;
    longint lo, hi, q;
    n = active_knots();
    k = $urandom_range(n - 1);
    r = $urandom_range(99);
    if (r < 30) begin
      q = knot_x[k];
    end else if (r < 60) begin
      k  = $urandom_range(n - 2);
      lo = knot_x[k];
      hi = knot_x[k+1];
      q  = (hi > lo) ? lo + longint'($urandom) % (hi - lo) : lo;
    end else if (r < 75) begin
      if ($urandom_range(1) == 0) q = knot_x[0] - longint'($urandom_range(32'h4_0000, 1));
      else q = knot_x[n-1] + longint'($urandom_range(32'h4_0000, 1));
    end else begin
      q = longint'($signed($urandom));
    end
    issue(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, q[31:0], 1'b0, NO_RES);
  endtask

  // result side: checks each beat, stalls at random, holds off twice for long
  initial begin
    int      hold_left;
    bit      quiet;
    interp_t want;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (interp_q.size() == 0) begin
          $error("result with none pending: value %h status %0d",
                 out_bus.value, out_bus.status);
          fails++;
        end else begin
          want = interp_q.pop_front();
          if (out_bus.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_bus.value);
            fails++;
          end
          if (out_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_bus.status);
            fails++;
          end
        end
        results_seen++;
        // long hold-off lets the block fill up and stall its input
        if (results_seen == 300 || results_seen == 900) hold_left = HOLD_CYCLES;
      end
      quiet = results_seen >= 400 && results_seen < 600;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= quiet || $urandom_range(99) >= 9;
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("[table_linear_interpolator] ERROR");
    $finish;
  end

  initial begin
    int start, phase, cnt, nq;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = OP_LOAD;
    in_bus.point_index = '0;
    in_bus.point_x     = '0;
    in_bus.point_y     = '0;
    in_bus.query_x     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_LEN; r++)
      issue(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].x, DIR_ROWS[r].y,
            DIR_ROWS[r].qx, DIR_ROWS[r].chk, DIR_ROWS[r].res);

    // phases: new knot count, full table load, then queries with a little noise
    start = items_sent;
    phase = 0;
    while (items_sent - start < RAND_ITEMS) begin
      if (phase < PLAN_LEN) begin
        cnt = COUNT_PLAN[phase];
      end else begin
        case ($urandom_range(9))
          8:       cnt = $urandom_range(64, 9);
          9:       cnt = $urandom_range(127);
          default: cnt = $urandom_range(8, 2);
        endcase
      end
      phase++;
      set_knot_count(CNT_W'(cnt));
      load_table();
      nq = $urandom_range(100, 40);
      repeat (nq) begin
        if ($urandom_range(99) < 6)
          issue(OP_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom, 1'b0, NO_RES);
        else
          random_query();
      end
    end

    drain();
    if (fails == 0) begin
      $display("[table_linear_interpolator] OK");
    end else begin
      $display("[table_linear_interpolator] ERROR");
    end
    $finish;
  end

endmodule
